>>> rtl/core/pcm_format_to_s16_converter_core_defines.svh
// assertion macros shared by the pcm format converter core
`ifndef PCM_FORMAT_TO_S16_CONVERTER_CORE_DEFINES_SVH
`define PCM_FORMAT_TO_S16_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PFS16_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PFS16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pfs16_pkg.sv
// shared types, constants and helpers for the pcm format converter core
package pfs16_pkg;

    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int FRAME_W    = 24;
    localparam int SAMPLE_W   = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // register indexes on the configuration port
    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT   = 2'd2;

    typedef enum logic [2:0] {
        FMT_U8       = 3'd0,
        FMT_S16BE    = 3'd1,
        FMT_S16LE    = 3'd2,
        FMT_S24BE    = 3'd3,
        FMT_S24LE    = 3'd4,
        FMT_F32BE    = 3'd5,
        FMT_F32LE    = 3'd6,
        FMT_RESERVED = 3'd7
    } pfs16_fmt_t;

    // operand class seen by the float back end
    typedef enum logic [2:0] {
        CLS_INT,
        CLS_NAN,
        CLS_INF,
        CLS_ZERO,
        CLS_NORM
    } pfs16_cls_t;

    typedef struct packed {
        pfs16_fmt_t           fmt;
        logic [1:0]           channels;
        logic [FRAME_W-1:0]   frames;
    } pfs16_cfg_t;

    // word holds float bits, or the finished integer sample in its low half
    typedef struct packed {
        logic [31:0] word;
        logic        is_float;
        logic        channel;
        logic        last;
    } pfs16_entry_t;

    function automatic logic [2:0] bytes_per_sample(input pfs16_fmt_t fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_U8:                 n = 3'd1;
            FMT_S16BE, FMT_S16LE:   n = 3'd2;
            FMT_S24BE, FMT_S24LE:   n = 3'd3;
            FMT_F32BE, FMT_F32LE:   n = 3'd4;
            FMT_RESERVED:           n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/pfs16_front.sv
// byte assembly, format decode and channel / frame counting
module pfs16_front
    import pfs16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pfs16_cfg_t    cfg,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          fifo_full,
    output logic          in_ready,
    output logic          push,
    output pfs16_entry_t  push_entry
);

    logic [1:0]         byte_pos_reg, byte_pos_next;
    logic [23:0]        asm_reg, asm_next;
    logic               chan_reg, chan_next;
    logic [FRAME_W-1:0] frames_reg, frames_next;

    logic [2:0]         n_bytes;
    logic               active;
    logic               complete;
    logic               frame_end;
    logic               is_last;
    logic [FRAME_W-1:0] frames_m1;

    assign in_ready = !fifo_full;

    always_comb
    begin
        n_bytes   = bytes_per_sample(cfg.fmt);
        active    = in_valid && in_ready && (cfg.fmt != FMT_RESERVED);
        complete  = ({1'b0, byte_pos_reg} + 3'd1) >= n_bytes;
        frame_end = !cfg.channels[1] || chan_reg;
        frames_m1 = cfg.frames - FRAME_W'(1);
        is_last   = frame_end && (frames_reg == frames_m1);
        push      = active && complete;

        push_entry.channel  = chan_reg;
        push_entry.last     = is_last;
        push_entry.is_float = 1'b0;
        unique case (cfg.fmt)
            FMT_U8:       push_entry.word = {16'h0000, in_byte ^ 8'h80, 8'h00};
            FMT_S16BE:    push_entry.word = {16'h0000, asm_reg[7:0], in_byte};
            FMT_S16LE:    push_entry.word = {16'h0000, in_byte, asm_reg[7:0]};
            FMT_S24BE:    push_entry.word = {16'h0000, asm_reg[15:0]};
            FMT_S24LE:    push_entry.word = {16'h0000, in_byte, asm_reg[7:0]};
            FMT_F32BE:
            begin
                push_entry.word     = {asm_reg, in_byte};
                push_entry.is_float = 1'b1;
            end
            FMT_F32LE:
            begin
                push_entry.word     = {in_byte, asm_reg[7:0], asm_reg[15:8], asm_reg[23:16]};
                push_entry.is_float = 1'b1;
            end
            FMT_RESERVED: push_entry.word = 32'h0000_0000;
        endcase

        byte_pos_next = byte_pos_reg;
        asm_next      = asm_reg;
        chan_next     = chan_reg;
        frames_next   = frames_reg;
        if (active)
        begin
            if (!complete)
            begin
                asm_next      = {asm_reg[15:0], in_byte};
                byte_pos_next = byte_pos_reg + 2'd1;
            end
            else
            begin
                asm_next      = '0;
                byte_pos_next = '0;
                if (is_last)
                begin
                    frames_next = '0;
                    chan_next   = 1'b0;
                end
                else if (frame_end)
                begin
                    frames_next = frames_reg + FRAME_W'(1);
                    chan_next   = 1'b0;
                end
                else
                begin
                    chan_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            asm_reg      <= '0;
            chan_reg     <= 1'b0;
            frames_reg   <= '0;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
            asm_reg      <= asm_next;
            chan_reg     <= chan_next;
            frames_reg   <= frames_next;
        end
    end

endmodule

>>> rtl/core/pfs16_fifo.sv
// short queue between the front and back parts
`include "pcm_format_to_s16_converter_core_defines.svh"

module pfs16_fifo
    import pfs16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pfs16_entry_t  push_entry,
    output logic          full,
    input  logic          pop,
    output pfs16_entry_t  pop_entry,
    output logic          empty
);

    pfs16_entry_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `PFS16_ASSERT_NOW(a_no_overflow, push, !full, "queue written while full")
    `PFS16_ASSERT_NOW(a_no_underflow, pop, !empty, "queue read while empty")
    `PFS16_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not follow a lone write")

endmodule

>>> rtl/core/pfs16_back.sv
// float scaling pipeline and output register
module pfs16_back
    import pfs16_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_empty,
    input  pfs16_entry_t        pop_entry,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,
    output logic [1:0]          m_axis_tuser,
    output logic                m_axis_tlast
);

    // stage 1: classify and form sig * 32767 as (sig << 15) - sig
    logic               s1_valid_reg, s1_valid_next;
    pfs16_cls_t         s1_cls_reg, s1_cls_next;
    logic               s1_neg_reg;
    logic [7:0]         s1_ex_reg;
    logic [38:0]        s1_prod_reg, s1_prod_next;   // integer sample in low bits
    logic               s1_channel_reg, s1_last_reg;

    // stage 2: round to 24 bits, work out the shift
    logic               s2_valid_reg, s2_valid_next;
    pfs16_cls_t         s2_cls_reg;
    logic               s2_neg_reg;
    logic [24:0]        s2_keep_reg, s2_keep_next;
    logic               s2_big_reg, s2_big_next;
    logic [4:0]         s2_shamt_reg, s2_shamt_next;
    logic               s2_channel_reg, s2_last_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic               clipped_reg, clipped_next;
    logic               channel_reg, last_reg;

    logic               out_ready, s2_ready, s1_ready;
    logic [23:0]        sig;
    logic [7:0]         ex;
    logic [22:0]        man;
    logic [23:0]        keep;
    logic               round_up;
    logic [4:0]         sh;
    logic signed [9:0]  t_sh;
    logic [24:0]        mag;

    assign out_ready = !out_valid_reg || m_axis_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = !fifo_empty && s1_ready;

    assign s1_valid_next  = s1_ready ? pop : s1_valid_reg;
    assign s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;

    always_comb
    begin
        ex  = pop_entry.word[30:23];
        man = pop_entry.word[22:0];
        sig = {1'b1, man};
        s1_prod_next = {sig, 15'b0} - {15'b0, sig};
        priority if (!pop_entry.is_float)
        begin
            s1_cls_next  = CLS_INT;
            s1_prod_next = {23'b0, pop_entry.word[15:0]};
        end
        else if (ex == 8'hFF)
        begin
            s1_cls_next = (man != '0) ? CLS_NAN : CLS_INF;
        end
        else if (ex == 8'h00)
        begin
            s1_cls_next = CLS_ZERO;
        end
        else
        begin
            s1_cls_next = CLS_NORM;
        end
    end

    // a normal significand times 32767 has its top bit at 38 or 37
    always_comb
    begin
        if (s1_prod_reg[38])
        begin
            keep     = s1_prod_reg[38:15];
            round_up = s1_prod_reg[14] && ((|s1_prod_reg[13:0]) || s1_prod_reg[15]);
            sh       = 5'd15;
        end
        else
        begin
            keep     = s1_prod_reg[37:14];
            round_up = s1_prod_reg[13] && ((|s1_prod_reg[12:0]) || s1_prod_reg[14]);
            sh       = 5'd14;
        end
        t_sh          = 10'sd150 - $signed({2'b00, s1_ex_reg}) - $signed({5'b00000, sh});
        s2_big_next   = (t_sh <= 10'sd0);
        s2_shamt_next = (t_sh >= 10'sd25) ? 5'd25 : t_sh[4:0];
        if (s1_cls_reg == CLS_INT)
        begin
            s2_keep_next = s1_prod_reg[24:0];
        end
        else
        begin
            s2_keep_next = {1'b0, keep} + {24'b0, round_up};
        end
    end

    always_comb
    begin
        mag          = s2_keep_reg >> s2_shamt_reg;
        sample_next  = '0;
        clipped_next = 1'b0;
        unique case (s2_cls_reg)
            CLS_INT:
            begin
                sample_next = s2_keep_reg[15:0];
            end
            CLS_NAN, CLS_ZERO:
            begin
                sample_next = '0;
            end
            CLS_INF:
            begin
                sample_next  = s2_neg_reg ? 16'h8000 : 16'h7FFF;
                clipped_next = 1'b1;
            end
            CLS_NORM:
            begin
                if (s2_neg_reg)
                begin
                    if (s2_big_reg || (mag > 25'd32768))
                    begin
                        sample_next  = 16'h8000;
                        clipped_next = 1'b1;
                    end
                    else
                    begin
                        sample_next = 16'h0000 - mag[15:0];
                    end
                end
                else
                begin
                    if (s2_big_reg || (mag > 25'd32767))
                    begin
                        sample_next  = 16'h7FFF;
                        clipped_next = 1'b1;
                    end
                    else
                    begin
                        sample_next = mag[15:0];
                    end
                end
            end
            default:
            begin
                sample_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cls_reg     <= s1_cls_next;
            s1_neg_reg     <= pop_entry.word[31];
            s1_ex_reg      <= ex;
            s1_prod_reg    <= s1_prod_next;
            s1_channel_reg <= pop_entry.channel;
            s1_last_reg    <= pop_entry.last;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_cls_reg     <= s1_cls_reg;
            s2_neg_reg     <= s1_neg_reg;
            s2_keep_reg    <= s2_keep_next;
            s2_big_reg     <= s2_big_next;
            s2_shamt_reg   <= s2_shamt_next;
            s2_channel_reg <= s1_channel_reg;
            s2_last_reg    <= s1_last_reg;
        end
        if (out_ready && s2_valid_reg)
        begin
            sample_reg  <= sample_next;
            clipped_reg <= clipped_next;
            channel_reg <= s2_channel_reg;
            last_reg    <= s2_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = sample_reg;
    assign m_axis_tuser  = {clipped_reg, channel_reg};
    assign m_axis_tlast  = last_reg;

endmodule

>>> rtl/core/pcm_format_to_s16_converter_core.sv
// top level of the pcm format to signed 16-bit converter
//
// raw audio bytes enter on the s_axis side, one byte per beat, in stream order.
// a beat that ends a sample pushes it into a four-entry queue; the back part
// scales floats by 32767 (round to single, truncate, saturate) and presents one
// signed 16-bit sample per beat on m_axis: tdata is the sample, tuser[0] the
// channel, tuser[1] the clipped flag, tlast marks the last sample of the block.
// the byte side takes one byte per cycle while the queue is not full; a finished
// sample passes through the queue slot, the product stage, the rounding stage
// and then the output register before it appears on m_axis.
// the output register and the queue let the byte side keep going while a
// result waits; when the receiver stalls, the pipeline fills and s_axis_tready
// drops only once the queue is full.
// reset clears the byte assembly, channel and frame counters and the pipeline;
// registers return to u8, mono, one frame. configure over apb between blocks.
module pcm_format_to_s16_converter_core
    import pfs16_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] in_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,   // [15:0] sample
    output logic [1:0]          m_axis_tuser,   // [0] channel, [1] clipped
    output logic                m_axis_tlast
);

    pfs16_fmt_t          fmt_reg;
    logic [1:0]          chan_cnt_reg;
    logic [FRAME_W-1:0]  frame_cnt_reg;
    logic                wr_en;

    pfs16_cfg_t          cfg;
    logic                push, pop, full, empty;
    pfs16_entry_t        push_entry, pop_entry;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_U8;
            chan_cnt_reg  <= 2'd1;
            frame_cnt_reg <= FRAME_W'(1);
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SAMPLE_FORMAT: fmt_reg       <= pfs16_fmt_t'(pwdata[2:0]);
                REG_CHANNEL_COUNT: chan_cnt_reg  <= pwdata[1:0];
                REG_FRAME_COUNT:   frame_cnt_reg <= pwdata[FRAME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SAMPLE_FORMAT: prdata = {29'b0, fmt_reg};
            REG_CHANNEL_COUNT: prdata = {30'b0, chan_cnt_reg};
            REG_FRAME_COUNT:   prdata = {8'b0, frame_cnt_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.fmt      = fmt_reg;
    assign cfg.channels = chan_cnt_reg;
    assign cfg.frames   = frame_cnt_reg;

    pfs16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .fifo_full  (full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    pfs16_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    pfs16_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (empty),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
